### hdl/lbcg_pkg.sv
// Shared types, widths and register codes of the blanking connector generator.
package lbcg_pkg;

    localparam int COORD_W   = 16;
    localparam int SEG_W     = 6;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 1;

    localparam int SHORT_LINE_SEGMENTS_DEF = 4;
    localparam int CLAMP_MARGIN_DEF        = 2;

    localparam logic [COORD_W-1:0] PREV_RESET      = 16'h8000;
    localparam logic [COORD_W-1:0] CONNECT_MIN_RST = 16'd655;
    localparam logic [COORD_W-1:0] SHORT_MAX_RST   = 16'd1966;
    localparam logic [SEG_W-1:0]   LONG_SEG_RST    = 6'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINK_PREV = 8'd0,
        CFG_MIN_DIST  = 8'd1,
        CFG_SHORT_MAX = 8'd2,
        CFG_LONG_SEGS = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [SEG_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COORD_W-1:0] quotient;
        logic [SEG_W-1:0]   remainder;
    } div_rsp_t;

endpackage

### hdl/lbcg_junction_if.sv
// Junction channel: the two end points of a stroke gap and their flags.
interface lbcg_junction_if;
    logic                        valid;
    logic                        ready;
    logic [lbcg_pkg::COORD_W-1:0] from_x;
    logic [lbcg_pkg::COORD_W-1:0] from_y;
    logic [lbcg_pkg::COORD_W-1:0] to_x;
    logic [lbcg_pkg::COORD_W-1:0] to_y;
    logic                        frame_start;
    logic                        strokes_usable;

    modport source (output valid, from_x, from_y, to_x, to_y, frame_start, strokes_usable,
                    input ready);
    modport sink (input valid, from_x, from_y, to_x, to_y, frame_start, strokes_usable,
                  output ready);
endinterface

### hdl/lbcg_point_if.sv
// Point channel: one blanked connector point per beat.
interface lbcg_point_if;
    logic                        valid;
    logic                        ready;
    logic [lbcg_pkg::COORD_W-1:0] point_x;
    logic [lbcg_pkg::COORD_W-1:0] point_y;
    logic                        run_last;

    modport source (output valid, point_x, point_y, run_last, input ready);
    modport sink (input valid, point_x, point_y, run_last, output ready);
endinterface

### hdl/lbcg_cfg_if.sv
// Configuration write channel: register index and write data.
interface lbcg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lbcg_pkg::CFG_IDX_W-1:0] index;
    logic [lbcg_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/laser_blanking_connector_gen.sv
// Top level of the blanked connector generator for a laser point stream.
// Sequence: a junction is taken in the idle state, its deltas are formed, squared and summed, the
// thresholds are squared, and the junction is decided; one that draws nothing is then finished.
// A drawing junction runs two divisions and then emits its n+1 points one per cycle while the
// receiver is ready. Only one junction is in work at a time; the next is taken once it is done.
// Reset: asynchronous, active low; registers take their documented values and the stored
// previous-frame point returns to the centre of the field.
module laser_blanking_connector_gen #(
    parameter int SHORT_LINE_SEGMENTS = lbcg_pkg::SHORT_LINE_SEGMENTS_DEF,
    parameter int CLAMP_MARGIN        = lbcg_pkg::CLAMP_MARGIN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    lbcg_junction_if.sink   junction,
    lbcg_point_if.source    points,
    lbcg_cfg_if.sink        cfg
);
    import lbcg_pkg::*;

    // Clamp window of an ordinary connector. The upper bound saturates at full scale.
    localparam int CLAMP_HI_RAW = 65536 - CLAMP_MARGIN;
    localparam int CLAMP_HI_INT = (CLAMP_HI_RAW > 65535) ? 65535 : CLAMP_HI_RAW;
    localparam logic [COORD_W-1:0] CLAMP_LO = COORD_W'(CLAMP_MARGIN);
    localparam logic [COORD_W-1:0] CLAMP_HI = COORD_W'(CLAMP_HI_INT);
    localparam logic [SEG_W-1:0]   SHORT_N  = SEG_W'(SHORT_LINE_SEGMENTS);

    // The sequencer: take the junction, form the two deltas, square them and the two
    // thresholds on the one multiplier, decide, and for a junction that draws, divide each
    // delta by the segment count, then step out the points.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DIFF    = 10'b00_0000_0010,
        S_SQX     = 10'b00_0000_0100,
        S_SQY     = 10'b00_0000_1000,
        S_SQMIN   = 10'b00_0001_0000,
        S_SQSHORT = 10'b00_0010_0000,
        S_DECIDE  = 10'b00_0100_0000,
        S_DIVX    = 10'b00_1000_0000,
        S_DIVY    = 10'b01_0000_0000,
        S_EMIT    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic               link_reg;
    logic [COORD_W-1:0] min_dist_reg;
    logic [COORD_W-1:0] short_max_reg;
    logic [SEG_W-1:0]   long_segs_reg;

    // Last point of the frame so far.
    logic [COORD_W-1:0] prev_x_reg;
    logic [COORD_W-1:0] prev_y_reg;

    // Junction under work.
    logic [COORD_W-1:0] ax_reg;
    logic [COORD_W-1:0] ay_reg;
    logic [COORD_W-1:0] bx_reg;
    logic [COORD_W-1:0] by_reg;
    logic               fstart_reg;
    logic               usable_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               negx_reg;
    logic               negy_reg;

    // Multiplier and distance compare.
    logic [COORD_W-1:0] mul_op;
    logic [SQ_W-1:0]    prod_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [SQ_W-1:0]    min_sq_reg;

    // Decision.
    logic               draw;
    logic               clamp_new;
    logic [SEG_W-1:0]   n_new;
    logic [SEG_W-1:0]   n_reg;
    logic               clamp_reg;

    // Point stepping: each coordinate keeps quotient and remainder of (d*j + n/2) / n, and
    // moves on by the precomputed quotient and remainder of d / n.
    logic [COORD_W-1:0] step_qx_reg;
    logic [SEG_W-1:0]   step_rx_reg;
    logic [COORD_W-1:0] step_qy_reg;
    logic [SEG_W-1:0]   step_ry_reg;
    logic [COORD_W-1:0] qx_reg;
    logic [SEG_W-1:0]   rx_reg;
    logic [COORD_W-1:0] qy_reg;
    logic [SEG_W-1:0]   ry_reg;
    logic [SEG_W-1:0]   j_reg;
    logic [SEG_W:0]     rx_sum;
    logic [SEG_W:0]     ry_sum;
    logic               rx_wrap;
    logic               ry_wrap;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [COORD_W-1:0] pt_x;
    logic [COORD_W-1:0] pt_y;
    logic               pt_last;
    logic               load;

    // Output register.
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic               out_last_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    lbcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign junction.ready = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;

    // Register writes. Unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg      <= 1'b1;
            min_dist_reg  <= CONNECT_MIN_RST;
            short_max_reg <= SHORT_MAX_RST;
            long_segs_reg <= LONG_SEG_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LINK_PREV: link_reg      <= cfg.data[0];
                CFG_MIN_DIST:  min_dist_reg  <= cfg.data[COORD_W-1:0];
                CFG_SHORT_MAX: short_max_reg <= cfg.data[COORD_W-1:0];
                CFG_LONG_SEGS: long_segs_reg <= cfg.data[SEG_W-1:0];
                default:       ;
            endcase
        end
    end

    // The single multiplier squares whichever operand the current state needs. Its product
    // is registered, and the sum of the two squares is formed from the registered products.
    always_comb
    begin
        case (state_reg)
            S_SQY:     mul_op = dy_reg;
            S_SQMIN:   mul_op = min_dist_reg;
            S_SQSHORT: mul_op = short_max_reg;
            default:   mul_op = dx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_op * mul_op;
    end

    // A frame-start junction draws an unclamped short line when linking is on and it is strictly
    // longer than the connection minimum. An ordinary one with usable strokes draws nothing below
    // that minimum, a short line below the short-line distance (whose square is in the product
    // register here), and a long line otherwise; one without usable strokes draws nothing. The
    // thresholds are tested in that order, so a short-line distance below the minimum gives no short lines.
    always_comb
    begin
        draw      = 1'b0;
        clamp_new = 1'b1;
        n_new     = SHORT_N;
        if (fstart_reg)
        begin
            draw      = link_reg && (d2_reg > {1'b0, min_sq_reg});
            clamp_new = 1'b0;
        end
        else if (usable_reg && (d2_reg >= {1'b0, min_sq_reg}))
        begin
            draw = 1'b1;
            if (d2_reg >= {1'b0, prod_reg})
            begin
                n_new = (long_segs_reg == '0) ? SEG_W'(1) : long_segs_reg;
            end
        end
    end

    always_comb
    begin
        div_req.start    = ((state_reg == S_DECIDE) && draw) ||
                           ((state_reg == S_DIVX) && div_rsp.done);
        div_req.dividend = (state_reg == S_DIVX) ? dy_reg : dx_reg;
        div_req.divisor  = (state_reg == S_DECIDE) ? n_new : n_reg;
    end

    // Current point from its running quotient, then the advance to the next one. The
    // remainder stays below n, so one compare and subtract keeps it there.
    always_comb
    begin
        raw_x   = negx_reg ? (ax_reg - qx_reg) : (ax_reg + qx_reg);
        raw_y   = negy_reg ? (ay_reg - qy_reg) : (ay_reg + qy_reg);
        pt_x    = raw_x;
        pt_y    = raw_y;
        if (clamp_reg)
        begin
            if (raw_x < CLAMP_LO)
                pt_x = CLAMP_LO;
            else if (raw_x > CLAMP_HI)
                pt_x = CLAMP_HI;
            if (raw_y < CLAMP_LO)
                pt_y = CLAMP_LO;
            else if (raw_y > CLAMP_HI)
                pt_y = CLAMP_HI;
        end
        pt_last = (j_reg == n_reg);
        rx_sum  = {1'b0, rx_reg} + {1'b0, step_rx_reg};
        ry_sum  = {1'b0, ry_reg} + {1'b0, step_ry_reg};
        rx_wrap = (rx_sum >= {1'b0, n_reg});
        ry_wrap = (ry_sum >= {1'b0, n_reg});
        load    = (state_reg == S_EMIT) && (!out_valid_reg || points.ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (junction.valid) state_next = S_DIFF;
            S_DIFF:    state_next = S_SQX;
            S_SQX:     state_next = S_SQY;
            S_SQY:     state_next = S_SQMIN;
            S_SQMIN:   state_next = S_SQSHORT;
            S_SQSHORT: state_next = S_DECIDE;
            S_DECIDE:  state_next = draw ? S_DIVX : S_IDLE;
            S_DIVX:    if (div_rsp.done) state_next = S_DIVY;
            S_DIVY:    if (div_rsp.done) state_next = S_EMIT;
            S_EMIT:    if (load && pt_last) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_x_reg    <= PREV_RESET;
            prev_y_reg    <= PREV_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (points.ready)
                out_valid_reg <= 1'b0;
            // With linking on, an ordinary junction leaves its last point behind, or its stroke end
            // when it draws nothing. A frame-start junction leaves the stored point alone.
            if ((state_reg == S_DECIDE) && !draw && !fstart_reg && link_reg)
            begin
                prev_x_reg <= ax_reg;
                prev_y_reg <= ay_reg;
            end
            else if (load && pt_last && !fstart_reg && link_reg)
            begin
                prev_x_reg <= pt_x;
                prev_y_reg <= pt_y;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (junction.valid && junction.ready)
        begin
            ax_reg     <= junction.frame_start ? prev_x_reg : junction.from_x;
            ay_reg     <= junction.frame_start ? prev_y_reg : junction.from_y;
            bx_reg     <= junction.to_x;
            by_reg     <= junction.to_y;
            fstart_reg <= junction.frame_start;
            usable_reg <= junction.strokes_usable;
        end
        if (state_reg == S_DIFF)
        begin
            negx_reg <= (bx_reg < ax_reg);
            negy_reg <= (by_reg < ay_reg);
            dx_reg   <= (bx_reg < ax_reg) ? (ax_reg - bx_reg) : (bx_reg - ax_reg);
            dy_reg   <= (by_reg < ay_reg) ? (ay_reg - by_reg) : (by_reg - ay_reg);
        end
        if (state_reg == S_SQY)
            d2_reg <= {1'b0, prod_reg};
        if (state_reg == S_SQMIN)
            d2_reg <= d2_reg + {1'b0, prod_reg};
        if (state_reg == S_SQSHORT)
            min_sq_reg <= prod_reg;
        if (state_reg == S_DECIDE)
        begin
            n_reg     <= n_new;
            clamp_reg <= clamp_new;
        end
        if ((state_reg == S_DIVX) && div_rsp.done)
        begin
            step_qx_reg <= div_rsp.quotient;
            step_rx_reg <= div_rsp.remainder;
        end
        if ((state_reg == S_DIVY) && div_rsp.done)
        begin
            step_qy_reg <= div_rsp.quotient;
            step_ry_reg <= div_rsp.remainder;
            qx_reg      <= '0;
            qy_reg      <= '0;
            rx_reg      <= n_reg >> 1;
            ry_reg      <= n_reg >> 1;
            j_reg       <= '0;
        end
        if (load)
        begin
            out_x_reg    <= pt_x;
            out_y_reg    <= pt_y;
            out_last_reg <= pt_last;
            j_reg        <= j_reg + 1'b1;
            qx_reg       <= qx_reg + step_qx_reg + COORD_W'(rx_wrap);
            qy_reg       <= qy_reg + step_qy_reg + COORD_W'(ry_wrap);
            rx_reg       <= rx_wrap ? SEG_W'(rx_sum - {1'b0, n_reg}) : rx_sum[SEG_W-1:0];
            ry_reg       <= ry_wrap ? SEG_W'(ry_sum - {1'b0, n_reg}) : ry_sum[SEG_W-1:0];
        end
    end

    assign points.valid    = out_valid_reg;
    assign points.point_x  = out_x_reg;
    assign points.point_y  = out_y_reg;
    assign points.run_last = out_last_reg;

`ifndef SYNTHESIS
    // The divider is only started when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The point counter never runs past the segment count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (j_reg <= n_reg))
        else $error("point index beyond segment count");

    // The running remainders stay below the segment count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ((rx_reg < n_reg) && (ry_reg < n_reg)))
        else $error("interpolation remainder out of range");

    // The final point of a connector carries the run marker and ends the junction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && pt_last) |=> (out_last_reg && (state_reg == S_IDLE)))
        else $error("connector did not close on its last point");
`endif

endmodule

### hdl/lbcg_div.sv
// Bit-serial restoring divider: 16-bit dividend by a 6-bit segment count.
module lbcg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lbcg_pkg::div_req_t req,
    output lbcg_pkg::div_rsp_t rsp
);
    import lbcg_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [COORD_W-1:0] quo_next;
    logic [SEG_W-1:0]   rem_reg;
    logic [SEG_W-1:0]   rem_next;
    logic [SEG_W-1:0]   div_reg;
    logic [SEG_W:0]     shifted;
    logic [SEG_W:0]     diff;
    logic               ge;

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[COORD_W-1]};
        diff     = shifted - {1'b0, div_reg};
        ge       = (shifted >= {1'b0, div_reg});
        rem_next = ge ? diff[SEG_W-1:0] : shifted[SEG_W-1:0];
        quo_next = {quo_reg[COORD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(COORD_W - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
